// ===== rtl/ucl_pkg.sv =====
// Shared types, constants and control structs for the unary-coded LZ decoder.
`default_nettype none
package ucl_pkg;

  // Defaults for the top-level parameters
  localparam int WINDOW_DEPTH_DEF = 16384;
  localparam int OUT_LANES_DEF    = 8;
  localparam int MAX_LANES        = 8;

  // Token coding constants
  localparam logic [3:0] LEN_PREFIX_MAX = 4'd7;
  localparam logic [3:0] DIST_WIDTH_MIN = 4'd9;
  localparam logic [3:0] DIST_WIDTH_MAX = 4'd13;
  localparam logic [3:0] LIT_WIDTH      = 4'd8;
  localparam logic [8:0] LEN_BIAS       = 9'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RANGE_CHECK_ON = 2'd0;
  localparam logic [1:0] REG_LOWEST_BYTE    = 2'd1;
  localparam logic [1:0] REG_HIGHEST_BYTE   = 2'd2;
  localparam logic [1:0] REG_EXPECTED_SIZE  = 2'd3;

  // Token parse phase
  typedef enum logic [4:0] {
    PH_LEN_PRE  = 5'b00001,
    PH_LEN_SUF  = 5'b00010,
    PH_LIT      = 5'b00100,
    PH_DIST_PRE = 5'b01000,
    PH_DIST_SUF = 5'b10000
  } phase_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BIT  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_WR   = 5'b01000,
    ST_END  = 5'b10000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic bit_step;
    logic copy_rd;
    logic copy_wr;
    logic push;
    logic push_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic halted;
    logic bits_done;
    logic lit_next;
    logic copy_go;
    logic full;
    logic cnt_last;
    logic pending;
    logic flag_any;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/ucl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ucl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ucl_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/ucl_datapath.sv =====
// Datapath: bit parser, history window, lane packer, output word register and config.
`default_nettype none
module ucl_datapath #(
  parameter int WINDOW_DEPTH = ucl_pkg::WINDOW_DEPTH_DEF,
  parameter int OUT_LANES    = ucl_pkg::OUT_LANES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ucl_pkg::cmd_t       cmd,
  output ucl_pkg::sts_t            sts,
  input  wire logic [7:0]          in_byte,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [7:0]               out_lane [ucl_pkg::MAX_LANES],
  output logic [3:0]               out_cnt,
  output logic                     out_last,
  output logic                     out_rng,
  output logic                     out_done
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int Lanes = (OUT_LANES > ucl_pkg::MAX_LANES) ? ucl_pkg::MAX_LANES :
                         ((OUT_LANES < 1) ? 1 : OUT_LANES);
  localparam logic [AW:0] DEPTH_EXT = (AW+1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_DEPTH - 1);

  // config registers
  logic        rc_on_r;
  logic [7:0]  lo_r, hi_r;
  logic [31:0] exp_r;

  // parser state
  logic [7:0]      byte_r, byte_nxt;
  logic [3:0]      left_r, left_nxt;
  ucl_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]      fw_r, fw_nxt;
  logic [13:0]     base_r, base_nxt;
  logic [12:0]     buf_r, buf_nxt;
  logic [3:0]      held_r, held_nxt;
  logic [8:0]      mlen_r, mlen_nxt;
  logic [8:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]   src_r, src_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic            wrapped_r, wrapped_nxt;
  logic [31:0]     prod_r, prod_nxt;
  logic            halted_r, halted_nxt;
  logic            rng_r, rng_nxt;
  logic            done_r, done_nxt;
  logic [3:0]      fill_r, fill_nxt;
  logic [7:0]      lane_r [ucl_pkg::MAX_LANES];

  // output word register
  logic            out_valid_r;
  logic [7:0]      out_lane_r [ucl_pkg::MAX_LANES];
  logic [3:0]      out_cnt_r;
  logic            out_last_r, out_rng_r, out_done_r;

  logic            b;
  logic [12:0]     buf_sh;
  logic [3:0]      held_inc;
  logic            lit_emit, emit_en, fail, emit_ok, token_end;
  logic [7:0]      emit_val, ram_rdata;
  logic            src_ok;
  logic [31:0]     prod_inc;
  logic [13:0]     dist_sum;
  logic [AW:0]     diff;
  logic            out_free;

  assign b        = byte_r[7];
  assign buf_sh   = {buf_r[11:0], b};
  assign held_inc = held_r + 4'd1;
  assign out_free = !out_valid_r || !out_stall;

  // window entries never written read as zero
  assign src_ok   = wrapped_r || (src_r < wp_r);

  // byte emission shared by literals and copies
  assign lit_emit  = cmd.bit_step && (phase_r == ucl_pkg::PH_LIT) && (held_inc >= ucl_pkg::LIT_WIDTH);
  assign emit_en   = lit_emit || cmd.copy_wr;
  assign emit_val  = lit_emit ? buf_sh[7:0] : (src_ok ? ram_rdata : 8'd0);
  assign fail      = rc_on_r && ((emit_val < lo_r) || (emit_val > hi_r));
  assign emit_ok   = emit_en && !fail;
  assign prod_inc  = (prod_r == 32'hFFFF_FFFF) ? prod_r : prod_r + 32'd1;
  assign token_end = emit_ok && (lit_emit || (cnt_r == 9'd1));

  // copy source: distance plus one behind the write position
  assign dist_sum = base_r + {1'b0, buf_sh};
  assign diff = {1'b0, wp_r} - (AW+1)'(dist_sum) - (AW+1)'(1);

  ucl_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (emit_en),
    .waddr (wp_r),
    .wdata (emit_val),
    .re    (cmd.copy_rd),
    .raddr (src_r),
    .rdata (ram_rdata)
  );

  // next-state logic for the parser
  always_comb begin
    byte_nxt    = byte_r;
    left_nxt    = left_r;
    phase_nxt   = phase_r;
    fw_nxt      = fw_r;
    base_nxt    = base_r;
    buf_nxt     = buf_r;
    held_nxt    = held_r;
    mlen_nxt    = mlen_r;
    cnt_nxt     = cnt_r;
    src_nxt     = src_r;
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    prod_nxt    = prod_r;
    halted_nxt  = halted_r;
    rng_nxt     = rng_r;
    done_nxt    = done_r;
    fill_nxt    = fill_r;

    if (cmd.load) begin
      byte_nxt = in_byte;
      left_nxt = 4'd8;
      fill_nxt = 4'd0;
      rng_nxt  = 1'b0;
      done_nxt = 1'b0;
      if ((phase_r == ucl_pkg::PH_LEN_PRE) && (fw_r == 4'd0) && (prod_r >= exp_r)) begin
        halted_nxt = 1'b1;
        done_nxt   = 1'b1;
      end
    end

    if (cmd.bit_step) begin
      byte_nxt = {byte_r[6:0], 1'b0};
      left_nxt = left_r - 4'd1;
      case (phase_r)
        ucl_pkg::PH_LEN_PRE: begin
          if (b) begin
            base_nxt = base_r + (14'd1 << fw_r);
            fw_nxt   = fw_r + 4'd1;
            if (fw_r + 4'd1 >= ucl_pkg::LEN_PREFIX_MAX) begin
              phase_nxt = ucl_pkg::PH_LEN_SUF;
              buf_nxt   = 13'd0;
              held_nxt  = 4'd0;
            end
          end else begin
            phase_nxt = (fw_r == 4'd0) ? ucl_pkg::PH_LIT : ucl_pkg::PH_LEN_SUF;
            buf_nxt   = 13'd0;
            held_nxt  = 4'd0;
          end
        end
        ucl_pkg::PH_LEN_SUF: begin
          buf_nxt  = buf_sh;
          held_nxt = held_inc;
          if (held_inc >= fw_r) begin
            mlen_nxt  = base_r[8:0] + buf_sh[8:0] + ucl_pkg::LEN_BIAS;
            fw_nxt    = ucl_pkg::DIST_WIDTH_MIN;
            base_nxt  = 14'd0;
            phase_nxt = ucl_pkg::PH_DIST_PRE;
            buf_nxt   = 13'd0;
            held_nxt  = 4'd0;
          end
        end
        ucl_pkg::PH_LIT: begin
          buf_nxt  = buf_sh;
          held_nxt = held_inc;
        end
        ucl_pkg::PH_DIST_PRE: begin
          if (b) begin
            base_nxt = base_r + (14'd1 << fw_r);
            fw_nxt   = fw_r + 4'd1;
            if (fw_r + 4'd1 >= ucl_pkg::DIST_WIDTH_MAX) begin
              phase_nxt = ucl_pkg::PH_DIST_SUF;
              buf_nxt   = 13'd0;
              held_nxt  = 4'd0;
            end
          end else begin
            phase_nxt = ucl_pkg::PH_DIST_SUF;
            buf_nxt   = 13'd0;
            held_nxt  = 4'd0;
          end
        end
        ucl_pkg::PH_DIST_SUF: begin
          buf_nxt  = buf_sh;
          held_nxt = held_inc;
          if (held_inc >= fw_r) begin
            cnt_nxt = mlen_r;
            src_nxt = diff[AW] ? AW'(diff + DEPTH_EXT) : diff[AW-1:0];
          end
        end
        default: begin
          phase_nxt = ucl_pkg::PH_LEN_PRE;
        end
      endcase
    end

    // copy step: advance source and count
    if (cmd.copy_wr) begin
      cnt_nxt = cnt_r - 9'd1;
      src_nxt = (src_r == LAST_POS) ? '0 : src_r + AW'(1);
    end

    // emitted byte
    if (emit_en) begin
      if (fail) begin
        halted_nxt = 1'b1;
        rng_nxt    = 1'b1;
      end else begin
        fill_nxt = fill_r + 4'd1;
        prod_nxt = prod_inc;
        if (wp_r == LAST_POS) begin
          wp_nxt      = '0;
          wrapped_nxt = 1'b1;
        end else begin
          wp_nxt = wp_r + AW'(1);
        end
      end
    end

    // next token begins
    if (token_end) begin
      phase_nxt = ucl_pkg::PH_LEN_PRE;
      fw_nxt    = 4'd0;
      base_nxt  = 14'd0;
      buf_nxt   = 13'd0;
      held_nxt  = 4'd0;
      if (prod_inc >= exp_r) begin
        halted_nxt = 1'b1;
        done_nxt   = 1'b1;
      end
    end

    if (cmd.push) begin
      fill_nxt = 4'd0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= 4'd0;
      phase_r   <= ucl_pkg::PH_LEN_PRE;
      fw_r      <= 4'd0;
      base_r    <= 14'd0;
      buf_r     <= 13'd0;
      held_r    <= 4'd0;
      mlen_r    <= 9'd0;
      cnt_r     <= 9'd0;
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      prod_r    <= 32'd0;
      halted_r  <= 1'b0;
      rng_r     <= 1'b0;
      done_r    <= 1'b0;
      fill_r    <= 4'd0;
    end else begin
      left_r    <= left_nxt;
      phase_r   <= phase_nxt;
      fw_r      <= fw_nxt;
      base_r    <= base_nxt;
      buf_r     <= buf_nxt;
      held_r    <= held_nxt;
      mlen_r    <= mlen_nxt;
      cnt_r     <= cnt_nxt;
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      prod_r    <= prod_nxt;
      halted_r  <= halted_nxt;
      rng_r     <= rng_nxt;
      done_r    <= done_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    src_r  <= src_nxt;
    if (emit_ok) begin
      lane_r[fill_r[2:0]] <= emit_val;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_on_r <= 1'b0;
      lo_r    <= 8'd0;
      hi_r    <= 8'hFF;
      exp_r   <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        ucl_pkg::REG_RANGE_CHECK_ON: rc_on_r <= cfg_wdata[0];
        ucl_pkg::REG_LOWEST_BYTE:    lo_r    <= cfg_wdata[7:0];
        ucl_pkg::REG_HIGHEST_BYTE:   hi_r    <= cfg_wdata[7:0];
        ucl_pkg::REG_EXPECTED_SIZE:  exp_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int k = 0; k < ucl_pkg::MAX_LANES; k++) begin
        out_lane_r[k] <= (4'(k) < fill_r) ? lane_r[k] : 8'd0;
      end
      out_cnt_r  <= fill_r;
      out_last_r <= cmd.push_last;
      out_rng_r  <= cmd.push_last && rng_r;
      out_done_r <= cmd.push_last && done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_lane  = out_lane_r;
  assign out_cnt   = out_cnt_r;
  assign out_last  = out_last_r;
  assign out_rng   = out_rng_r;
  assign out_done  = out_done_r;

  // status to controller
  always_comb begin
    sts.halted    = halted_r;
    sts.bits_done = (left_r == 4'd0);
    sts.lit_next  = (phase_r == ucl_pkg::PH_LIT) && (held_inc >= ucl_pkg::LIT_WIDTH);
    sts.copy_go   = (phase_r == ucl_pkg::PH_DIST_SUF) && (held_inc >= fw_r);
    sts.full      = (fill_r == 4'(Lanes));
    sts.cnt_last  = (cnt_r == 9'd1);
    sts.pending   = (fill_r != 4'd0) || rng_r || done_r;
    sts.flag_any  = rng_r || done_r;
    sts.out_free  = out_free;
  end

endmodule
`default_nettype wire

// ===== rtl/ucl_ctrl.sv =====
// Controller: sequences bit steps, window copies and output word pushes.
`default_nettype none
module ucl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ucl_pkg::sts_t sts,
  output ucl_pkg::cmd_t      cmd
);

  ucl_pkg::state_t state_r, state_nxt;

  assign in_stall = (state_r != ucl_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ucl_pkg::ST_IDLE: begin
        // a halted block swallows its input
        if (in_valid && !sts.halted) begin
          cmd.load  = 1'b1;
          state_nxt = ucl_pkg::ST_BIT;
        end
      end
      ucl_pkg::ST_BIT: begin
        if (sts.halted || sts.bits_done) begin
          state_nxt = ucl_pkg::ST_END;
        end else if (sts.lit_next && sts.full) begin
          // make room before the literal lands
          cmd.push = sts.out_free;
        end else begin
          cmd.bit_step = 1'b1;
          if (sts.copy_go) begin
            state_nxt = ucl_pkg::ST_RD;
          end
        end
      end
      ucl_pkg::ST_RD: begin
        if (sts.halted) begin
          state_nxt = ucl_pkg::ST_BIT;
        end else begin
          cmd.copy_rd = 1'b1;
          state_nxt   = ucl_pkg::ST_WR;
        end
      end
      ucl_pkg::ST_WR: begin
        if (sts.full) begin
          cmd.push = sts.out_free;
        end else begin
          cmd.copy_wr = 1'b1;
          state_nxt   = sts.cnt_last ? ucl_pkg::ST_BIT : ucl_pkg::ST_RD;
        end
      end
      ucl_pkg::ST_END: begin
        if (!sts.pending) begin
          state_nxt = ucl_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push = 1'b1;
          // a full word ahead of a flag goes out on its own first
          if (!(sts.full && sts.flag_any)) begin
            cmd.push_last = 1'b1;
            state_nxt     = ucl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ucl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ucl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/unary_coded_lz_decoder.sv =====
// Top level of the unary-coded LZ decoder: controller plus datapath.
//
// Input channel: one compressed byte per word (in_valid / in_stall), bits
// taken most significant first. Output channel: words of up to OUT_LANES
// decoded bytes (at most 8) with a byte count, a last-of-run mark on the
// final word caused by an input byte, and halt flags for a range failure or
// for reaching the expected size. Configuration is a plain write port.
// Sequence: an input byte that copies nothing passes through the accepting
// cycle, a bit-parse step for each of its 8 bits, a step that sees the byte
// used up and a closing step that pushes the last word (or finds none to
// send). Each byte copied out of the history window adds a RAM read, then
// the write-back, and each word pushed before the last adds a push step;
// a literal adds nothing. A halt cuts the byte short.
// The output word sits in a register, so a stalled receiver holds only that
// word; the decoder keeps working until it needs to push another word.
// Reset clears the parser, the write position and the output register; the
// window needs no clearing pass, since entries not yet written read as zero.
// Once halted, input bytes are still taken but give no output until reset.
`default_nettype none
module unary_coded_lz_decoder #(
  parameter int WINDOW_DEPTH = ucl_pkg::WINDOW_DEPTH_DEF,
  parameter int OUT_LANES    = ucl_pkg::OUT_LANES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_packed_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte_0,
  output logic [7:0]       out_byte_1,
  output logic [7:0]       out_byte_2,
  output logic [7:0]       out_byte_3,
  output logic [7:0]       out_byte_4,
  output logic [7:0]       out_byte_5,
  output logic [7:0]       out_byte_6,
  output logic [7:0]       out_byte_7,
  output logic [3:0]       out_byte_count,
  output logic             out_last_of_run,
  output logic             out_out_of_range,
  output logic             out_finished,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  ucl_pkg::cmd_t cmd;
  ucl_pkg::sts_t sts;
  logic [7:0]    lane [ucl_pkg::MAX_LANES];

  ucl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ucl_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .OUT_LANES    (OUT_LANES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_packed_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_lane  (lane),
    .out_cnt   (out_byte_count),
    .out_last  (out_last_of_run),
    .out_rng   (out_out_of_range),
    .out_done  (out_finished)
  );

  assign out_byte_0 = lane[0];
  assign out_byte_1 = lane[1];
  assign out_byte_2 = lane[2];
  assign out_byte_3 = lane[3];
  assign out_byte_4 = lane[4];
  assign out_byte_5 = lane[5];
  assign out_byte_6 = lane[6];
  assign out_byte_7 = lane[7];

endmodule
`default_nettype wire

// ===== tb/unary_coded_lz_decoder_test.sv =====
// Self-checking testbench for the unary-coded LZ decoder.
`timescale 1ns / 1ps
module unary_coded_lz_decoder_test;

  localparam int WIN = ucl_pkg::WINDOW_DEPTH_DEF;
  localparam int LANE_MAX = 8;
  localparam int DRAIN_CYCLES = 700;

  typedef struct packed {
    logic [63:0] lanes;
    logic [3:0]  count;
    logic        last;
    logic        oor;
    logic        fin;
  } chunk_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_packed_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte_0, out_byte_1, out_byte_2, out_byte_3;
  logic [7:0] out_byte_4, out_byte_5, out_byte_6, out_byte_7;
  logic [3:0] out_byte_count;
  logic out_last_of_run, out_out_of_range, out_finished;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = ucl_pkg::REG_RANGE_CHECK_ON;
  logic [31:0] cfg_wdata = 32'd0;

  unary_coded_lz_decoder dut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pacing controls, changed only on the falling edge
  int send_idle = 26;
  int recv_idle = 45;
  int hold_req = 0;
  int hold_left = 0;

  logic [7:0] feed_q[$];
  chunk_t chunk_q[$];
  chunk_t pend_q[$];
  bit bits_q[$];
  int errors = 0;
  int words_seen = 0;
  int bytes_sent = 0;
  int range_halts = 0;
  int size_halts = 0;

  // Decoder shadow state
  logic [7:0]      hist[WIN];
  int unsigned     wpos, bbuf, bheld, fwidth, abase, mlen, prod;
  ucl_pkg::phase_t phase;
  bit              halted, f_rng, f_done;
  logic            rc_on;
  logic [7:0]      lo_b, hi_b;
  logic [31:0]     exp_size;
  logic [63:0]     lane_acc;
  int unsigned     fill;

  function automatic void flush_word();
    chunk_t c;
    c.lanes = lane_acc;
    c.count = fill[3:0];
    c.last = 1'b0;
    c.oor = 1'b0;
    c.fin = 1'b0;
    pend_q.push_back(c);
    lane_acc = '0;
    fill = 0;
  endfunction

  function automatic bit put_byte(logic [7:0] t);
    hist[wpos] = t;
    if (rc_on && (t < lo_b || t > hi_b)) begin
      halted = 1;
      f_rng = 1;
      return 0;
    end
    lane_acc[8*fill +: 8] = t;
    fill++;
    if (fill >= LANE_MAX) flush_word();
    if (prod != 32'hFFFF_FFFF) prod++;
    wpos = (wpos + 1 >= WIN) ? 0 : wpos + 1;
    return 1;
  endfunction

  function automatic void new_token();
    phase = ucl_pkg::PH_LEN_PRE;
    fwidth = 0;
    abase = 0;
    bbuf = 0;
    bheld = 0;
    if (prod >= exp_size) begin
      halted = 1;
      f_done = 1;
    end
  endfunction

  function automatic void to_field(ucl_pkg::phase_t nxt);
    phase = nxt;
    bbuf = 0;
    bheld = 0;
  endfunction

  function automatic void copy_back(int unsigned back_dist);
    int unsigned src, n;
    src = (wpos + WIN - back_dist - 1) % WIN;
    for (n = 0; n < mlen; n++) begin
      if (!put_byte(hist[src])) return;
      src = (src + 1 >= WIN) ? 0 : src + 1;
    end
    new_token();
  endfunction

  function automatic void parse_bit(bit b);
    case (phase)
      ucl_pkg::PH_LEN_PRE: begin
        if (b) begin
          abase += 1 << fwidth;
          fwidth++;
          if (fwidth >= ucl_pkg::LEN_PREFIX_MAX) to_field(ucl_pkg::PH_LEN_SUF);
        end else if (fwidth == 0) begin
          to_field(ucl_pkg::PH_LIT);
        end else begin
          to_field(ucl_pkg::PH_LEN_SUF);
        end
      end
      ucl_pkg::PH_LEN_SUF: begin
        bbuf = ((bbuf << 1) | b) & 16'hFFFF;
        bheld++;
        if (bheld >= fwidth) begin
          mlen = (abase + bbuf + ucl_pkg::LEN_BIAS) & 9'h1FF;
          fwidth = ucl_pkg::DIST_WIDTH_MIN;
          abase = 0;
          to_field(ucl_pkg::PH_DIST_PRE);
        end
      end
      ucl_pkg::PH_LIT: begin
        bbuf = ((bbuf << 1) | b) & 16'hFFFF;
        bheld++;
        if (bheld >= ucl_pkg::LIT_WIDTH) begin
          if (put_byte(bbuf[7:0])) new_token();
        end
      end
      ucl_pkg::PH_DIST_PRE: begin
        if (b) begin
          abase += 1 << fwidth;
          fwidth++;
          if (fwidth >= ucl_pkg::DIST_WIDTH_MAX) to_field(ucl_pkg::PH_DIST_SUF);
        end else begin
          to_field(ucl_pkg::PH_DIST_SUF);
        end
      end
      default: begin
        bbuf = ((bbuf << 1) | b) & 16'hFFFF;
        bheld++;
        if (bheld >= fwidth) copy_back((abase + bbuf) & 14'h3FFF);
      end
    endcase
  endfunction

  // Expected words for one compressed byte
  function automatic void decode_byte(logic [7:0] b);
    chunk_t c;
    if (halted) return;
    pend_q.delete();
    lane_acc = '0;
    fill = 0;
    f_rng = 0;
    f_done = 0;
    if (phase == ucl_pkg::PH_LEN_PRE && fwidth == 0 && prod >= exp_size) begin
      halted = 1;
      f_done = 1;
    end
    for (int k = 7; k >= 0 && !halted; k--) parse_bit(b[k]);
    if (fill > 0 || f_rng || f_done) flush_word();
    if (pend_q.size() > 0) begin
      c = pend_q.pop_back();
      c.last = 1'b1;
      c.oor = f_rng;
      c.fin = f_done;
      pend_q.push_back(c);
    end
    range_halts += f_rng;
    size_halts += f_done;
    foreach (pend_q[i]) chunk_q.push_back(pend_q[i]);
  endfunction

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (feed_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_packed_byte <= feed_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Monitor: config shadow, prediction on accepted words, output checks
  always @(posedge clk) begin
    chunk_t e;
    logic [63:0] got;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        ucl_pkg::REG_RANGE_CHECK_ON: rc_on = cfg_wdata[0];
        ucl_pkg::REG_LOWEST_BYTE:    lo_b = cfg_wdata[7:0];
        ucl_pkg::REG_HIGHEST_BYTE:   hi_b = cfg_wdata[7:0];
        ucl_pkg::REG_EXPECTED_SIZE:  exp_size = cfg_wdata;
        default: begin
        end
      endcase
    end
    if (rst_n && in_valid && !in_stall) begin
      bytes_sent++;
      decode_byte(in_packed_byte);
    end
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      got = {out_byte_7, out_byte_6, out_byte_5, out_byte_4,
             out_byte_3, out_byte_2, out_byte_1, out_byte_0};
      if (chunk_q.size() == 0) begin
        $error("unexpected output word, byte_count %0d", out_byte_count);
        errors++;
      end else begin
        e = chunk_q.pop_front();
        for (int k = 0; k < LANE_MAX; k++)
          if (got[8*k +: 8] !== e.lanes[8*k +: 8]) begin
            $error("byte_%0d: expected %0h, got %0h", k, e.lanes[8*k +: 8], got[8*k +: 8]);
            errors++;
          end
        if (out_byte_count !== e.count) begin
          $error("byte_count: expected %0d, got %0d", e.count, out_byte_count);
          errors++;
        end
        if (out_last_of_run !== e.last) begin
          $error("last_of_run: expected %0b, got %0b", e.last, out_last_of_run);
          errors++;
        end
        if (out_out_of_range !== e.oor) begin
          $error("out_of_range: expected %0b, got %0b", e.oor, out_out_of_range);
          errors++;
        end
        if (out_finished !== e.fin) begin
          $error("finished: expected %0b, got %0b", e.fin, out_finished);
          errors++;
        end
      end
    end
  end

  // Token encoding into the bit stream, packed into bytes MSB first
  task automatic put_bits(int unsigned v, int n);
    for (int k = n - 1; k >= 0; k--) bits_q.push_back(v[k]);
    while (bits_q.size() >= 8) begin
      logic [7:0] b;
      for (int k = 7; k >= 0; k--) b[k] = bits_q.pop_front();
      feed_q.push_back(b);
    end
  endtask

  task automatic literal(logic [7:0] v);
    put_bits(0, 1);
    put_bits(v, 8);
  endtask

  // Match: w prefix ones (1..7), length suffix, d distance ones (0..4), suffix
  task automatic match(int w, int unsigned ls, int d, int unsigned ds);
    put_bits((1 << w) - 1, w);
    if (w < ucl_pkg::LEN_PREFIX_MAX) put_bits(0, 1);
    put_bits(ls, w);
    put_bits((1 << d) - 1, d);
    if (d < 4) put_bits(0, 1);
    put_bits(ds, ucl_pkg::DIST_WIDTH_MIN + d);
  endtask

  // Mostly well-formed tokens with short matches; some raw noise bytes
  task automatic random_stream(int nbytes);
    int goal;
    int w, d;
    goal = feed_q.size() + nbytes;
    while (feed_q.size() < goal) begin
      case ($urandom_range(9))
        0: put_bits($urandom_range(255), 8);
        1, 2, 3, 4: literal($urandom_range(255));
        default: begin
          w = ($urandom_range(15) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 2);
          d = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : 0;
          match(w, $urandom, d, ($urandom_range(3) == 0) ? $urandom : $urandom_range(20));
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (feed_q.size() > 0 || in_valid || chunk_q.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Shadow reset values
  initial begin
    foreach (hist[i]) hist[i] = 8'd0;
    wpos = 0; bbuf = 0; bheld = 0; fwidth = 0; abase = 0; mlen = 0; prod = 0;
    phase = ucl_pkg::PH_LEN_PRE;
    halted = 0;
    rc_on = 0; lo_b = 8'd0; hi_b = 8'd255; exp_size = 32'd0;
    lane_acc = '0;
    fill = 0;
  end

  // Stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Wide open: range on at the extremes, largest size
    cfg_write(ucl_pkg::REG_EXPECTED_SIZE, 32'hFFFF_FFFF);
    cfg_write(ucl_pkg::REG_RANGE_CHECK_ON, 1);
    cfg_write(ucl_pkg::REG_LOWEST_BYTE, 8'd0);
    cfg_write(ucl_pkg::REG_HIGHEST_BYTE, 8'd255);
    @(negedge clk);
    // directed tokens: extreme literals, copies from the cleared window,
    // full-width prefixes, longest match, overlap copy
    literal(8'h00);
    literal(8'hFF);
    literal(8'h80);
    literal(8'h01);
    match(1, 0, 0, 0);
    match(1, 1, 0, 3);
    match(7, 0, 0, 0);
    match(7, 32'h7F, 4, 32'h1FFF);
    match(3, 5, 1, 700);
    match(2, 3, 2, 0);
    match(6, 63, 3, 32'hFFF);
    literal(8'h7F);
    match(4, 9, 4, 0);
    literal(8'hA5);
    put_bits(0, 7);
    random_stream(80);
    wait_idle();

    // Swapped idling, range check off with an inverted range, long hold-off
    send_idle = 45;
    recv_idle = 26;
    cfg_write(ucl_pkg::REG_RANGE_CHECK_ON, 0);
    cfg_write(ucl_pkg::REG_LOWEST_BYTE, 8'hF0);
    cfg_write(ucl_pkg::REG_HIGHEST_BYTE, 8'h10);
    @(negedge clk);
    hold_req = 600;
    random_stream(100);
    wait_idle();

    // No idling; sender pauses until everything drains
    send_idle = 0;
    recv_idle = 0;
    cfg_write(ucl_pkg::REG_RANGE_CHECK_ON, 1);
    cfg_write(ucl_pkg::REG_LOWEST_BYTE, 8'd0);
    cfg_write(ucl_pkg::REG_HIGHEST_BYTE, 8'd255);
    @(negedge clk);
    random_stream(50);
    wait_idle();
    random_stream(50);
    wait_idle();

    // Narrow range and a near size limit: the block halts on one of them
    send_idle = 20;
    recv_idle = 20;
    cfg_write(ucl_pkg::REG_LOWEST_BYTE, 8'h08);
    cfg_write(ucl_pkg::REG_HIGHEST_BYTE, 8'hF7);
    cfg_write(ucl_pkg::REG_EXPECTED_SIZE, prod + $urandom_range(10, 60));
    @(negedge clk);
    random_stream(70);
    wait_idle();

    $display("compressed bytes: %0d, output words checked: %0d", bytes_sent, words_seen);
    $display("halts seen: range %0d, size %0d", range_halts, size_halts);
    if (errors == 0 && chunk_q.size() == 0)
      $display("unary_coded_lz_decoder regression: pass");
    else
      $display("unary_coded_lz_decoder regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("unary_coded_lz_decoder regression: fail");
    $finish;
  end

endmodule
